// ----- rtl/core/siph_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// siph_pkg: shared types, constants and round function
// Sizes, request/result layouts, controller commands and the SipHash
// half-round used by the hash-chain endpoint table.
// ----------------------------------------------------------------------------
package siph_pkg;

	localparam int CHAIN_LENGTH = 256;
	localparam int TABLE_BITS   = 16;
	localparam int TBL_DEPTH    = 1 << TABLE_BITS;

	localparam int STEP_W = (CHAIN_LENGTH > 1) ? $clog2(CHAIN_LENGTH) : 1;
	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(CHAIN_LENGTH - 1);

	localparam logic [63:0] TBL_MASK = (64'd1 << TABLE_BITS) - 64'd1;
	localparam logic [TABLE_BITS-1:0] CLR_LAST = {TABLE_BITS{1'b1}};

	// half-round sequencing within one hash step
	localparam logic [2:0] HALF_INJECT = 3'd1;
	localparam logic [2:0] HALF_LAST   = 3'd7;

	localparam logic [7:0] MSG_LEN_BYTE = 8'h0F;
	localparam logic [63:0] FINAL_XOR   = 64'h0000_0000_0000_00FF;

	localparam logic [8:0] HITS_MAX = 9'h1FF;
	localparam logic [7:0] STEP_SAT = 8'hFF;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_STATE_A = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STATE_B = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STATE_C = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_STATE_D = 2'd3;

	typedef struct packed {
		logic        func;
		logic [63:0] start_point;
	} siph_req_t;

	typedef struct packed {
		logic [63:0] end_point;
		logic [8:0]  hit_count;
		logic [7:0]  first_hit_step;
		logic [15:0] first_hit_start;
	} siph_res_t;

	typedef struct packed {
		logic                  capture;  // latch a new request
		logic                  load;     // init state words for a step
		logic                  round;    // one half-round
		logic [2:0]            half;
		logic                  rd;       // table probe read
		logic                  probe;    // compare probe result
		logic [STEP_W-1:0]     step;
		logic                  store;    // build mode endpoint write
		logic                  clr_we;   // clearing pass write
		logic [TABLE_BITS-1:0] clr_addr;
	} siph_cmd_t;

	typedef struct packed {
		logic search;
	} siph_stat_t;

	typedef struct packed {
		logic [63:0] v0;
		logic [63:0] v1;
		logic [63:0] v2;
		logic [63:0] v3;
	} siph_v_t;

	// phase 0: first half of a SipRound, phase 1: second half
	function automatic siph_v_t sip_half(input siph_v_t v, input logic phase);
		siph_v_t r;
		r = v;
		if (!phase) begin
			r.v0 = v.v0 + v.v1;
			r.v2 = v.v2 + v.v3;
			r.v1 = {v.v1[50:0], v.v1[63:51]} ^ r.v0;
			r.v3 = {v.v3[47:0], v.v3[63:48]} ^ r.v2;
			r.v0 = {r.v0[31:0], r.v0[63:32]};
		end else begin
			r.v2 = v.v2 + v.v1;
			r.v0 = v.v0 + v.v3;
			r.v1 = {v.v1[46:0], v.v1[63:47]} ^ r.v2;
			r.v3 = {v.v3[42:0], v.v3[63:43]} ^ r.v0;
			r.v2 = {r.v2[31:0], r.v2[63:32]};
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/core/siphash_chain_endpoint_table.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// siphash_chain_endpoint_table: SipHash-1-3 hash-chain endpoint table
// Walks a chain of hash steps from a start point; build mode stores the
// endpoint in a table, search mode probes the table after every step.
//
//   channel   ports                          handshake
//   -------   ----------------------------   ---------------------------
//   request   req.func, req.start_point      start high while busy low
//   result    result.*                       done, one cycle, no stall
//   config    cfg_index, cfg_data            cfg_we, taken every edge
//
// After reset a clearing pass zeroes all 2^TABLE_BITS entries of the table,
// one entry per cycle; busy is high and no request is taken. Each hash
// step is a load followed by eight half-rounds on a shared round unit;
// search mode adds a table read and a compare per step. A new request
// may be taken in the done cycle.
// ----------------------------------------------------------------------------
module siphash_chain_endpoint_table
	import siph_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output logic                      busy,
	input  wire siph_req_t            req,
	output logic                      done,
	output siph_res_t                 result,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [63:0]          cfg_data
);

	siph_cmd_t             cmd;
	siph_stat_t            stat;
	logic                  tbl_we;
	logic [TABLE_BITS-1:0] tbl_waddr;
	logic [63:0]           tbl_wdata;
	logic                  tbl_re;
	logic [TABLE_BITS-1:0] tbl_raddr;
	logic [63:0]           tbl_rdata;

	siph_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.stat   (stat),
		.cmd    (cmd)
	);

	siph_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.stat      (stat),
		.result    (result),
		.tbl_we    (tbl_we),
		.tbl_waddr (tbl_waddr),
		.tbl_wdata (tbl_wdata),
		.tbl_re    (tbl_re),
		.tbl_raddr (tbl_raddr),
		.tbl_rdata (tbl_rdata)
	);

	siph_table u_table (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (tbl_waddr),
		.wdata (tbl_wdata),
		.re    (tbl_re),
		.raddr (tbl_raddr),
		.rdata (tbl_rdata)
	);

endmodule
`default_nettype wire

// ----- rtl/core/siph_table.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// siph_table: endpoint table memory
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module siph_table
	import siph_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  we,
	input  wire logic [TABLE_BITS-1:0] waddr,
	input  wire logic [63:0]           wdata,
	input  wire logic                  re,
	input  wire logic [TABLE_BITS-1:0] raddr,
	output logic [63:0]                rdata
);

	logic [63:0] mem [TBL_DEPTH];
	logic [63:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// ----- rtl/core/siph_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// siph_dp: hash-chain datapath
// State word registers, shared half-round unit, chain value, hit tracking
// and the table port drive.
// ----------------------------------------------------------------------------
module siph_dp
	import siph_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire siph_req_t             req,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [63:0]           cfg_data,
	input  wire siph_cmd_t             cmd,
	output siph_stat_t                 stat,
	output siph_res_t                  result,
	output logic                       tbl_we,
	output logic [TABLE_BITS-1:0]      tbl_waddr,
	output logic [63:0]                tbl_wdata,
	output logic                       tbl_re,
	output logic [TABLE_BITS-1:0]      tbl_raddr,
	input  wire logic [63:0]           tbl_rdata
);

	logic [63:0] word_a_q, word_b_q, word_c_q, word_d_q;
	siph_v_t     v_q;
	logic [63:0] x_q;
	logic [63:0] start_q;
	logic        search_q;
	logic [8:0]  hits_q;
	logic [7:0]  first_step_q;
	logic [15:0] first_start_q;

	logic [63:0] msg;
	siph_v_t     half_out;
	logic        match;

	assign msg = {MSG_LEN_BYTE, x_q[55:0]};

	always_comb begin
		half_out = sip_half(v_q, cmd.half[0]);
		if (cmd.half == HALF_INJECT) begin
			half_out.v0 = half_out.v0 ^ msg;
			half_out.v2 = half_out.v2 ^ FINAL_XOR;
		end
	end

	assign match = (tbl_rdata & ~TBL_MASK) == (x_q & ~TBL_MASK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_a_q <= '0;
			word_b_q <= '0;
			word_c_q <= '0;
			word_d_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_STATE_A: word_a_q <= cfg_data;
				REG_STATE_B: word_b_q <= cfg_data;
				REG_STATE_C: word_c_q <= cfg_data;
				REG_STATE_D: word_d_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			search_q      <= 1'b0;
			hits_q        <= '0;
			first_step_q  <= '0;
			first_start_q <= '0;
		end else if (cmd.capture) begin
			search_q      <= req.func;
			hits_q        <= '0;
			first_step_q  <= '0;
			first_start_q <= '0;
		end else if (cmd.probe && match) begin
			if (hits_q == '0) begin
				first_step_q  <= (32'(cmd.step) > 32'd255) ? STEP_SAT : 8'(cmd.step);
				first_start_q <= 16'(tbl_rdata & TBL_MASK);
			end
			if (hits_q != HITS_MAX) begin
				hits_q <= hits_q + 9'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			x_q     <= req.start_point;
			start_q <= req.start_point;
		end else if (cmd.round && cmd.half == HALF_LAST) begin
			x_q <= (half_out.v0 ^ half_out.v1) ^ (half_out.v2 ^ half_out.v3);
		end
		if (cmd.load) begin
			v_q.v0 <= word_a_q;
			v_q.v1 <= word_b_q;
			v_q.v2 <= word_c_q;
			v_q.v3 <= word_d_q ^ msg;
		end else if (cmd.round) begin
			v_q <= half_out;
		end
	end

	assign tbl_we    = cmd.clr_we | cmd.store;
	assign tbl_waddr = cmd.clr_we ? cmd.clr_addr : x_q[TABLE_BITS-1:0];
	assign tbl_wdata = cmd.clr_we ? 64'd0 : ((x_q & ~TBL_MASK) | (start_q & TBL_MASK));
	assign tbl_re    = cmd.rd;
	assign tbl_raddr = x_q[TABLE_BITS-1:0];

	assign stat.search = search_q;

	assign result.end_point       = x_q;
	assign result.hit_count       = hits_q;
	assign result.first_hit_step  = first_step_q;
	assign result.first_hit_start = first_start_q;

endmodule
`default_nettype wire

// ----- rtl/core/siph_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// siph_ctrl: hash-chain sequencer
// Clearing pass after reset, then per request: per step a load,
// eight half-rounds and, in search mode, a table read and compare.
// ----------------------------------------------------------------------------
module siph_ctrl
	import siph_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	output logic            busy,
	output logic            done,
	input  wire siph_stat_t stat,
	output siph_cmd_t       cmd
);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOAD,
		ST_ROUND,
		ST_READ,
		ST_CMP,
		ST_FIN
	} state_t;

	state_t                state_q;
	logic [2:0]            half_q;
	logic [STEP_W-1:0]     step_q;
	logic [TABLE_BITS-1:0] clr_addr_q;
	logic                  done_q;

	logic accept;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign done   = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			half_q     <= '0;
			step_q     <= '0;
			clr_addr_q <= '0;
			done_q     <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == CLR_LAST) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						step_q  <= '0;
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					half_q  <= '0;
					state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					if (half_q == HALF_LAST) begin
						half_q <= '0;
						if (stat.search) begin
							state_q <= ST_READ;
						end else if (step_q == STEP_LAST) begin
							state_q <= ST_FIN;
						end else begin
							step_q  <= step_q + 1'b1;
							state_q <= ST_LOAD;
						end
					end else begin
						half_q <= half_q + 3'd1;
					end
				end
				ST_READ: begin
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (step_q == STEP_LAST) begin
						state_q <= ST_FIN;
					end else begin
						step_q  <= step_q + 1'b1;
						state_q <= ST_LOAD;
					end
				end
				ST_FIN: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd          = '0;
		cmd.half     = half_q;
		cmd.step     = step_q;
		cmd.clr_addr = clr_addr_q;
		cmd.capture  = accept;
		cmd.load     = (state_q == ST_LOAD);
		cmd.round    = (state_q == ST_ROUND);
		cmd.rd       = (state_q == ST_READ);
		cmd.probe    = (state_q == ST_CMP);
		cmd.store    = (state_q == ST_FIN) && !stat.search;
		cmd.clr_we   = (state_q == ST_CLEAR);
	end

	a_done_after_fin: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_FIN))
		else $error("result strobe without a finished chain");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for more than one cycle");

	a_accept_loads: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> state_q == ST_LOAD && step_q == '0)
		else $error("accepted request did not start a chain at step zero");

	a_half_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_ROUND |-> half_q == '0)
		else $error("half-round counter left nonzero outside rounds");

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= STEP_LAST)
		else $error("step counter beyond chain length");

endmodule
`default_nettype wire

// ----- tb/tb_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for siphash_chain_endpoint_table
// Sends build and search requests through start/busy and keeps a bench copy
// of the state words and the endpoint table. Every done result is checked
// field by field against the oldest prediction. The bench solves state words
// backwards so that chosen values become fixed points of one hash step. That
// reaches hits on cleared entries, full-length hit counts and overwritten slots.
// ----------------------------------------------------------------------------
module tb_top;
	import siph_pkg::*;

	localparam int   DRAIN_CYCLES = 3000;
	localparam int   STALL_LIMIT  = 250000;
	localparam int   PHASE_ITEMS  = 206;
	localparam logic FUNC_BUILD   = 1'b0;
	localparam logic FUNC_SEARCH  = 1'b1;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic                 busy;
	siph_req_t            req = '0;
	logic                 done;
	siph_res_t            result;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_STATE_A;
	logic [63:0]          cfg_data = '0;

	siphash_chain_endpoint_table u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.req      (req),
		.done     (done),
		.result   (result),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #6 clk = ~clk;

	siph_v_t     state_words = '0;
	bit [63:0]   shadow_table [TBL_DEPTH];
	siph_res_t   pending_results [$];
	int unsigned err_cnt = 0;
	int unsigned n_build = 0;
	int unsigned n_search = 0;
	int unsigned n_hit = 0;
	int unsigned n_cfg = 0;
	int unsigned stall_cnt = 0;
	bit          gaps_on = 1'b1;

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [63:0] rol(input logic [63:0] v, input int s);
		return (v << s) | (v >> (64 - s));
	endfunction

	function automatic logic [63:0] ror(input logic [63:0] v, input int s);
		return (v >> s) | (v << (64 - s));
	endfunction

	function automatic siph_v_t mix_round(input siph_v_t v);
		siph_v_t r;
		r = v;
		r.v0 = r.v0 + r.v1;
		r.v2 = r.v2 + r.v3;
		r.v1 = rol(r.v1, 13) ^ r.v0;
		r.v3 = rol(r.v3, 16) ^ r.v2;
		r.v0 = rol(r.v0, 32);
		r.v2 = r.v2 + r.v1;
		r.v0 = r.v0 + r.v3;
		r.v1 = rol(r.v1, 17) ^ r.v2;
		r.v3 = rol(r.v3, 21) ^ r.v0;
		r.v2 = rol(r.v2, 32);
		return r;
	endfunction

	// undoes mix_round, second half first
	function automatic siph_v_t unmix_round(input siph_v_t v);
		siph_v_t r;
		r = v;
		r.v2 = ror(r.v2, 32);
		r.v1 = ror(r.v1 ^ r.v2, 17);
		r.v3 = ror(r.v3 ^ r.v0, 21);
		r.v0 = r.v0 - r.v3;
		r.v2 = r.v2 - r.v1;
		r.v0 = ror(r.v0, 32);
		r.v1 = ror(r.v1 ^ r.v0, 13);
		r.v3 = ror(r.v3 ^ r.v2, 16);
		r.v0 = r.v0 - r.v1;
		r.v2 = r.v2 - r.v3;
		return r;
	endfunction

	function automatic logic [63:0] hash_once(input siph_v_t init, input logic [63:0] x);
		siph_v_t     v;
		logic [63:0] m;
		m = {MSG_LEN_BYTE, x[55:0]};
		v = init;
		v.v3 = v.v3 ^ m;
		v = mix_round(v);
		v.v0 = v.v0 ^ m;
		v.v2 = v.v2 ^ FINAL_XOR;
		for (int r = 0; r < 3; r++)
			v = mix_round(v);
		return v.v0 ^ v.v1 ^ v.v2 ^ v.v3;
	endfunction

	// state words under which one hash step maps src onto dst
	function automatic siph_v_t solve_words(input logic [63:0] src, input logic [63:0] dst);
		siph_v_t     v;
		logic [63:0] m;
		m = {MSG_LEN_BYTE, src[55:0]};
		v.v0 = rand64();
		v.v1 = rand64();
		v.v2 = rand64();
		v.v3 = dst ^ v.v0 ^ v.v1 ^ v.v2;
		for (int r = 0; r < 3; r++)
			v = unmix_round(v);
		v.v2 = v.v2 ^ FINAL_XOR;
		v.v0 = v.v0 ^ m;
		v = unmix_round(v);
		v.v3 = v.v3 ^ m;
		return v;
	endfunction

	function automatic logic [63:0] advance(input logic [63:0] x, input int unsigned k);
		logic [63:0] y;
		y = x;
		repeat (k) y = hash_once(state_words, y);
		return y;
	endfunction

	// walks one chain; build requests also update the bench table
	function automatic siph_res_t walk_chain(input logic search, input logic [63:0] origin);
		siph_res_t   r;
		logic [63:0] x;
		logic [63:0] entry;
		int unsigned hits;
		r = '0;
		x = origin;
		hits = 0;
		for (int i = 0; i < CHAIN_LENGTH; i++) begin
			x = hash_once(state_words, x);
			if (search) begin
				entry = shadow_table[x[TABLE_BITS-1:0]];
				if ((entry & ~TBL_MASK) == (x & ~TBL_MASK)) begin
					if (hits == 0) begin
						r.first_hit_step = (i > STEP_SAT) ? STEP_SAT : 8'(i);
						r.first_hit_start = 16'(entry & TBL_MASK);
					end
					if (hits < HITS_MAX)
						hits++;
				end
			end
		end
		if (!search)
			shadow_table[x[TABLE_BITS-1:0]] = (x & ~TBL_MASK) | (origin & TBL_MASK);
		r.end_point = x;
		r.hit_count = 9'(hits);
		return r;
	endfunction

	function automatic logic [63:0] rand_start();
		case ($urandom_range(7))
			0: return 64'(1) << $urandom_range(63);
			1: return ~(64'(1) << $urandom_range(63));
			default: return rand64();
		endcase
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 55)
			return 0;
		if (roll < 85)
			return $urandom_range(5, 1);
		if (roll < 97)
			return $urandom_range(80, 6);
		return $urandom_range(3200, 200);
	endfunction

	// start stays high into the next request when there is no gap
	task automatic send_request(input logic func, input logic [63:0] origin);
		int unsigned gap;
		siph_req_t   word;
		siph_res_t   predicted;
		gap = gaps_on ? pick_gap() : 0;
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		word.func = func;
		word.start_point = origin;
		start <= 1'b1;
		req <= word;
		do @(posedge clk); while (busy);
		predicted = walk_chain(func, origin);
		pending_results.push_back(predicted);
		if (func == FUNC_SEARCH)
			n_search++;
		else
			n_build++;
		if (predicted.hit_count != 0)
			n_hit++;
	endtask

	task automatic drain_results();
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic load_state(input siph_v_t w);
		drain_results();
		cfg_we <= 1'b1;
		cfg_index <= REG_STATE_A;
		cfg_data <= w.v0;
		@(posedge clk);
		cfg_index <= REG_STATE_B;
		cfg_data <= w.v1;
		@(posedge clk);
		cfg_index <= REG_STATE_C;
		cfg_data <= w.v2;
		@(posedge clk);
		cfg_index <= REG_STATE_D;
		cfg_data <= w.v3;
		@(posedge clk);
		cfg_we <= 1'b0;
		state_words = w;
		n_cfg++;
	endtask

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			$error("%s: expected %h, got %h", name, want, got);
			err_cnt++;
		end
	endtask

	always @(posedge clk) begin
		siph_res_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$error("done with no request outstanding, end_point %h", result.end_point);
				err_cnt++;
			end else begin
				want = pending_results.pop_front();
				check_field("end_point", want.end_point, result.end_point);
				check_field("hit_count", want.hit_count, result.hit_count);
				check_field("first_hit_step", want.first_hit_step, result.first_hit_step);
				check_field("first_hit_start", want.first_hit_start, result.first_hit_start);
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done) begin
			stall_cnt <= 0;
		end else if (stall_cnt == STALL_LIMIT) begin
			$display("watchdog: no request or result for %0d cycles", STALL_LIMIT);
			$display("DONE: errors detected");
			$finish;
		end else begin
			stall_cnt <= stall_cnt + 1;
		end
	end

	// reset state words; searches from built starts hit on the last step
	task automatic test_zero_state();
		logic [63:0] ones;
		ones = '1;
		send_request(FUNC_BUILD, 64'h0);
		send_request(FUNC_BUILD, ones);
		send_request(FUNC_BUILD, 64'h8000_0000_0000_0001);
		send_request(FUNC_SEARCH, 64'h0);
		send_request(FUNC_SEARCH, ones);
		send_request(FUNC_SEARCH, advance(ones, 100));
		send_request(FUNC_SEARCH, rand64());
	endtask

	// a small fixed point matches the cleared entry on every step
	task automatic test_cleared_entries();
		logic [63:0] fixed;
		fixed = {48'h0, 16'($urandom)};
		load_state(solve_words(fixed, fixed));
		send_request(FUNC_SEARCH, fixed);
		send_request(FUNC_SEARCH, rand64());
		send_request(FUNC_BUILD, fixed);
		send_request(FUNC_SEARCH, fixed);
	endtask

	// two fixed points share a slot; the second build replaces the first tag
	task automatic test_slot_overwrite();
		logic [63:0] first_pt;
		logic [63:0] second_pt;
		siph_v_t     first_words;
		first_pt = {32'($urandom) | 32'h1, 16'($urandom), 16'($urandom)};
		second_pt = {~first_pt[63:TABLE_BITS], first_pt[TABLE_BITS-1:0]};
		first_words = solve_words(first_pt, first_pt);
		load_state(first_words);
		send_request(FUNC_BUILD, first_pt);
		send_request(FUNC_SEARCH, first_pt);
		load_state(solve_words(second_pt, second_pt));
		send_request(FUNC_BUILD, second_pt);
		send_request(FUNC_SEARCH, second_pt);
		load_state(first_words);
		send_request(FUNC_SEARCH, first_pt);
	endtask

	task automatic test_saturated_state();
		logic [63:0] ones;
		ones = '1;
		load_state({ones, ones, ones, ones});
		send_request(FUNC_BUILD, ones);
		send_request(FUNC_BUILD, 64'h0);
		send_request(FUNC_SEARCH, 64'h0);
		send_request(FUNC_SEARCH, ones);
	endtask

	// builds, searches entering built chains at random depth, and noise
	task automatic test_random_chains();
		siph_v_t     words;
		logic [63:0] built [$];
		logic [63:0] origin;
		int unsigned roll;
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				1: words = '0;
				3: words = {64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
					64'h0, 64'hFFFF_FFFF_FFFF_FFFF};
				default: words = {rand64(), rand64(), rand64(), rand64()};
			endcase
			load_state(words);
			gaps_on = (ph != 1);
			built.delete();
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				roll = $urandom_range(99);
				if (built.size() == 0 || roll < 35) begin
					origin = rand_start();
					send_request(FUNC_BUILD, origin);
					built.push_back(origin);
				end else if (roll < 80) begin
					origin = built[$urandom_range(built.size() - 1)];
					send_request(FUNC_SEARCH, advance(origin, $urandom_range(CHAIN_LENGTH - 1)));
				end else begin
					send_request(FUNC_SEARCH, rand_start());
				end
			end
		end
		gaps_on = 1'b1;
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		// table clearing pass runs first
		while (busy !== 1'b1) @(posedge clk);
		test_zero_state();
		test_cleared_entries();
		test_slot_overwrite();
		test_saturated_state();
		test_random_chains();
		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("ran %0d builds and %0d searches, %0d of them expected to hit the table,",
			n_build, n_search, n_hit);
		$display("across %0d state word settings plus the reset setting", n_cfg);
		if (err_cnt == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
`default_nettype wire
